[hdl/nps_pkg.sv]
`default_nettype none
package nps_pkg;

  localparam int unsigned MAX_REF_POINTS_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF     = 32;
  localparam int unsigned IN_COORD_W         = 32;
  localparam int unsigned OUT_IDX_W          = 10;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic clr;
    logic wr;
    logic load_q;
    logic rd;
    logic emit;
    logic emit_empty;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic scan_last;
    logic pipe_empty;
  } dp_status_t;

endpackage
`default_nettype wire

[hdl/nps_ram.sv]
`default_nettype none
module nps_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[hdl/nps_ctrl.sv]
`default_nettype none
module nps_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [1:0]           in_command,
  input  wire nps_pkg::dp_status_t  sts,
  output nps_pkg::ctrl_cmd_t        cmd,
  output logic                      busy
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (nps_pkg::cmd_t'(in_command))
            nps_pkg::CMD_CLEAR:  cmd.clr = 1'b1;
            nps_pkg::CMD_APPEND: cmd.wr  = 1'b1;
            nps_pkg::CMD_QUERY: begin
              if (sts.cnt_zero) begin
                cmd.emit_empty = 1'b1;
              end else begin
                cmd.load_q = 1'b1;
                state_nxt  = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last distance has left the pipe once all stage valids are clear
        if (sts.pipe_empty) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

[hdl/nps_datapath.sv]
`default_nettype none
module nps_datapath #(
  parameter int unsigned MAX_REF_POINTS = nps_pkg::MAX_REF_POINTS_DEF,
  parameter int unsigned COORD_BITS     = nps_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire nps_pkg::ctrl_cmd_t                cmd,
  output nps_pkg::dp_status_t                    sts,
  input  wire logic [nps_pkg::IN_COORD_W-1:0]    in_point_x,
  input  wire logic [nps_pkg::IN_COORD_W-1:0]    in_point_y,
  output logic                                   out_valid,
  output logic [nps_pkg::OUT_IDX_W-1:0]          out_nearest_index,
  output logic                                   out_set_empty
);

  localparam int unsigned IDX_W = (MAX_REF_POINTS > 1) ? $clog2(MAX_REF_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_REF_POINTS + 1);
  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned SQ_W  = 2 * C;
  localparam int unsigned D_W   = SQ_W + 1;

  logic [CNT_W-1:0] count_r;
  logic             full;
  logic [C-1:0]     qx_r, qy_r;
  logic [IDX_W-1:0] scan_addr_r;
  logic [2*C-1:0]   rd_data;
  logic [C-1:0]     rx, ry;

  logic             s1_v_r, s2_v_r, s3_v_r;
  logic [IDX_W-1:0] s1_idx_r, s2_idx_r, s3_idx_r;
  logic [C:0]       dx, dy, ndx, ndy;
  logic [C-1:0]     adx_nxt, ady_nxt, adx_r, ady_r;
  logic [SQ_W-1:0]  sqx_r, sqy_r;
  logic [D_W-1:0]   sum_d, best_d_r;
  logic [IDX_W-1:0] best_idx_r;

  logic                         out_valid_r, out_set_empty_r;
  logic [nps_pkg::OUT_IDX_W-1:0] out_idx_r;

  assign full = (count_r == CNT_W'(MAX_REF_POINTS));

  nps_ram #(
    .WIDTH (2 * C),
    .DEPTH (MAX_REF_POINTS)
  ) u_ref_ram (
    .clk     (clk),
    .wr_en   (cmd.wr && !full),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data ({in_point_x[C-1:0], in_point_y[C-1:0]}),
    .rd_en   (cmd.rd),
    .rd_addr (scan_addr_r),
    .rd_data (rd_data)
  );

  assign rx = rd_data[2*C-1:C];
  assign ry = rd_data[C-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clr) begin
      count_r <= '0;
    end else if (cmd.wr && !full) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_q) begin
      qx_r <= in_point_x[C-1:0];
      qy_r <= in_point_y[C-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
    end else if (cmd.load_q) begin
      scan_addr_r <= '0;
    end else if (cmd.rd) begin
      scan_addr_r <= scan_addr_r + IDX_W'(1);
    end
  end

  // difference of two C-bit signed values fits C+1 bits, its magnitude C bits
  assign dx  = {qx_r[C-1], qx_r} - {rx[C-1], rx};
  assign dy  = {qy_r[C-1], qy_r} - {ry[C-1], ry};
  assign ndx = -dx;
  assign ndy = -dy;
  assign adx_nxt = dx[C] ? ndx[C-1:0] : dx[C-1:0];
  assign ady_nxt = dy[C] ? ndy[C-1:0] : dy[C-1:0];

  assign sum_d = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.rd;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= scan_addr_r;
    s2_idx_r <= s1_idx_r;
    s3_idx_r <= s2_idx_r;
    adx_r    <= adx_nxt;
    ady_r    <= ady_nxt;
    sqx_r    <= SQ_W'(adx_r) * SQ_W'(adx_r);
    sqy_r    <= SQ_W'(ady_r) * SQ_W'(ady_r);
    // strict less-than keeps the earliest index on a tie
    if (s3_v_r && (s3_idx_r == '0 || sum_d < best_d_r)) begin
      best_d_r   <= sum_d;
      best_idx_r <= s3_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit || cmd.emit_empty;
    end
  end

  always_ff @(posedge clk) begin
    out_set_empty_r <= cmd.emit_empty;
    out_idx_r       <= cmd.emit_empty ? '0 : nps_pkg::OUT_IDX_W'(best_idx_r);
  end

  assign sts.cnt_zero   = (count_r == '0);
  assign sts.scan_last  = ((CNT_W'(scan_addr_r) + CNT_W'(1)) == count_r);
  assign sts.pipe_empty = !(s1_v_r || s2_v_r || s3_v_r);

  assign out_valid         = out_valid_r;
  assign out_nearest_index = out_idx_r;
  assign out_set_empty     = out_set_empty_r;

endmodule
`default_nettype wire

[hdl/nearest_point_search.sv]
// Channel   | Ports                                         | Handshake
// ----------+-----------------------------------------------+------------------------------
// input     | in_command, in_point_x, in_point_y            | taken when start && !busy
// result    | out_nearest_index, out_set_empty              | out_valid strobe, one cycle
//
// Clear, append and a query on an empty set leave busy low.
// A query on N stored points holds busy while it scans and drains, and strobes its result
// in the first cycle with busy low again; one distance per cycle through the single
// read port of the reference memory, followed by the distance pipe.
// Reset (synchronous, active low) empties the set; the memory itself is not cleared.
// Results cannot be stalled: each is presented for exactly one cycle.
`default_nettype none
module nearest_point_search #(
  parameter int unsigned MAX_REF_POINTS = nps_pkg::MAX_REF_POINTS_DEF,
  parameter int unsigned COORD_BITS     = nps_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      in_command,
  input  wire logic [nps_pkg::IN_COORD_W-1:0]  in_point_x,
  input  wire logic [nps_pkg::IN_COORD_W-1:0]  in_point_y,
  output logic                                 out_valid,
  output logic [nps_pkg::OUT_IDX_W-1:0]        out_nearest_index,
  output logic                                 out_set_empty
);

  nps_pkg::ctrl_cmd_t  cmd;
  nps_pkg::dp_status_t sts;

  nps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  nps_datapath #(
    .MAX_REF_POINTS (MAX_REF_POINTS),
    .COORD_BITS     (COORD_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .out_valid         (out_valid),
    .out_nearest_index (out_nearest_index),
    .out_set_empty     (out_set_empty)
  );

endmodule
`default_nettype wire

[hdl/nps_checker.sv]
`default_nettype none
module nps_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic [1:0]                      in_command,
  input wire logic                            out_valid,
  input wire logic [nps_pkg::OUT_IDX_W-1:0]   out_nearest_index,
  input wire logic                            out_set_empty
);

  logic acc_query, acc_other;

  assign acc_query = start && !busy && (in_command == nps_pkg::CMD_QUERY);
  assign acc_other = start && !busy && (in_command != nps_pkg::CMD_QUERY);

  // a query either starts a scan or answers at once
  a_query_progress: assert property (@(posedge clk) disable iff (!rst_n)
    acc_query |=> (busy || out_valid))
    else $error("query item neither started a scan nor returned a result");

  a_no_result_other: assert property (@(posedge clk) disable iff (!rst_n)
    acc_other |=> !out_valid)
    else $error("result strobed after a clear or append item");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while still busy");

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("scan ended without a result");

  a_empty_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_set_empty) |-> (out_nearest_index == '0))
    else $error("empty-set result carries a nonzero index");

endmodule

bind nearest_point_search nps_checker u_nps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_command        (in_command),
  .out_valid         (out_valid),
  .out_nearest_index (out_nearest_index),
  .out_set_empty     (out_set_empty)
);
`default_nettype wire
